// ===== rtl/ray_box_slab_intersect_defines.svh =====
// Assertion macros shared by the ray box slab intersect RTL.
`ifndef RAY_BOX_SLAB_INTERSECT_DEFINES_SVH
`define RAY_BOX_SLAB_INTERSECT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define RBSI_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define RBSI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rbsi_pkg.sv =====
// Shared constants and register codes for the ray box slab intersect block.
`timescale 1ns / 1ps
package rbsi_pkg;

   localparam int FRAC_BITS      = 16;
   localparam int CSR_ADDR_WIDTH = 3;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_CORNER_A_X = 3'd0,
      CSR_CORNER_A_Y = 3'd1,
      CSR_CORNER_A_Z = 3'd2,
      CSR_CORNER_B_X = 3'd3,
      CSR_CORNER_B_Y = 3'd4,
      CSR_CORNER_B_Z = 3'd5
   } csr_index_type;

endpackage

// ===== rtl/ray_box_slab_intersect.sv =====
// Top level of the ray box slab intersect block.
//
//  channel | direction | transfer when       | payload
//  req     | in        | req_valid & !stall  | origin x/y/z, dir x/y/z
//  rsp     | out       | rsp_valid & !stall  | t_near, t_far
//  csr     | in        | csr_we              | csr_addr, csr_wdata
//
// One ray per cycle sustained while no result is stalled; the restoring dividers
// take one quotient bit per stage, COORD_WIDTH + 17 stages.
// Reset clears the corners to zero and empties the pipeline.
// A stalled result blocks new rays only once the next one reaches the end.
`timescale 1ns / 1ps
`include "ray_box_slab_intersect_defines.svh"
module ray_box_slab_intersect #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [COORD_WIDTH-1:0]          req_origin_x,
   input  logic signed [COORD_WIDTH-1:0]          req_origin_y,
   input  logic signed [COORD_WIDTH-1:0]          req_origin_z,
   input  logic signed [COORD_WIDTH-1:0]          req_dir_x,
   input  logic signed [COORD_WIDTH-1:0]          req_dir_y,
   input  logic signed [COORD_WIDTH-1:0]          req_dir_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [COORD_WIDTH-1:0]          rsp_t_near,
   output logic signed [COORD_WIDTH-1:0]          rsp_t_far,
   input  logic                                   csr_we,
   input  logic [rbsi_pkg::CSR_ADDR_WIDTH-1:0]    csr_addr,
   input  logic [COORD_WIDTH-1:0]                 csr_wdata
);
   localparam int W   = COORD_WIDTH;
   localparam int LAT = W + 1 + rbsi_pkg::FRAC_BITS + 3;

   logic signed [W-1:0] corner_a_x_ff, corner_a_y_ff, corner_a_z_ff;
   logic signed [W-1:0] corner_b_x_ff, corner_b_y_ff, corner_b_z_ff;
   logic [LAT-1:0]      v_ff;
   logic [LAT-1:0]      v_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                adv;
   logic                load;
   logic signed [W-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         corner_a_x_ff <= '0;
         corner_a_y_ff <= '0;
         corner_a_z_ff <= '0;
         corner_b_x_ff <= '0;
         corner_b_y_ff <= '0;
         corner_b_z_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            rbsi_pkg::CSR_CORNER_A_X: corner_a_x_ff <= csr_wdata;
            rbsi_pkg::CSR_CORNER_A_Y: corner_a_y_ff <= csr_wdata;
            rbsi_pkg::CSR_CORNER_A_Z: corner_a_z_ff <= csr_wdata;
            rbsi_pkg::CSR_CORNER_B_X: corner_b_x_ff <= csr_wdata;
            rbsi_pkg::CSR_CORNER_B_Y: corner_b_y_ff <= csr_wdata;
            rbsi_pkg::CSR_CORNER_B_Z: corner_b_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Advance the pipeline unless the last stage is blocked by a held result
   always_comb begin
      adv  = !(v_ff[LAT-1] && rsp_valid_ff && rsp_stall);
      load = adv && v_ff[LAT-1];
      v_in = {v_ff[LAT-2:0], req_valid};
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            v_ff <= v_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   rbsi_axis_lane #(.W(W)) u_lane_x (
      .clock(clock), .adv(adv), .corner_a(corner_a_x_ff), .corner_b(corner_b_x_ff),
      .origin(req_origin_x), .dir(req_dir_x), .t_lo(lo_x), .t_hi(hi_x)
   );

   rbsi_axis_lane #(.W(W)) u_lane_y (
      .clock(clock), .adv(adv), .corner_a(corner_a_y_ff), .corner_b(corner_b_y_ff),
      .origin(req_origin_y), .dir(req_dir_y), .t_lo(lo_y), .t_hi(hi_y)
   );

   rbsi_axis_lane #(.W(W)) u_lane_z (
      .clock(clock), .adv(adv), .corner_a(corner_a_z_ff), .corner_b(corner_b_z_ff),
      .origin(req_origin_z), .dir(req_dir_z), .t_lo(lo_z), .t_hi(hi_z)
   );

   rbsi_merge #(.W(W)) u_merge (
      .clock(clock), .load(load),
      .lo_x(lo_x), .lo_y(lo_y), .lo_z(lo_z),
      .hi_x(hi_x), .hi_y(hi_y), .hi_z(hi_z),
      .t_near(rsp_t_near), .t_far(rsp_t_far)
   );

   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;

   `RBSI_ASSERT_SAME(a_block_when_full, v_ff[LAT-1] && rsp_valid_ff && rsp_stall, req_stall, "blocked pipeline accepted a ray")
   `RBSI_ASSERT_NEXT(a_accept_enters, req_valid && !req_stall, v_ff[0], "accepted ray did not enter the pipeline")
   `RBSI_ASSERT_NEXT(a_drain_empty, rsp_valid_ff && !rsp_stall && !v_ff[LAT-1], !rsp_valid_ff, "result repeated after transfer")
endmodule

// ===== rtl/rbsi_div_lane.sv =====
// Pipelined restoring divider: ((plane - origin) << 16) / dir, truncated, saturated.
`timescale 1ns / 1ps
module rbsi_div_lane #(
   parameter int W = 32
) (
   input  logic                clock,
   input  logic                adv,
   input  logic signed [W-1:0] plane,
   input  logic signed [W-1:0] origin,
   input  logic signed [W-1:0] dir,
   output logic signed [W-1:0] quot
);
   localparam int DW = W + 1;
   localparam int N  = DW + rbsi_pkg::FRAC_BITS;
   localparam int RW = W + 1;
   localparam logic [N-1:0] HALF = {{(N-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
   localparam logic [N-1:0] MAXQ = HALF - 1'b1;
   localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};

   logic [N-1:0]  div_ff [0:N];
   logic [RW-1:0] rem_ff [0:N];
   logic [N-1:0]  quo_ff [0:N];
   logic [W-1:0]  dm_ff  [0:N];
   logic          neg_ff [0:N];
   logic [W-1:0]  quot_ff;
   logic [W-1:0]  quot_in;

   logic          nneg;
   logic [DW-1:0] diff;
   logic [DW-1:0] mag;
   logic [W-1:0]  dm;

   // Form exact difference magnitude and divisor magnitude
   always_comb begin
      nneg = plane < origin;
      diff = {plane[W-1], plane} - {origin[W-1], origin};
      mag  = nneg ? (~diff + 1'b1) : diff;
      dm   = dir[W-1] ? (~dir + 1'b1) : dir;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         div_ff[0] <= {mag, {rbsi_pkg::FRAC_BITS{1'b0}}};
         rem_ff[0] <= '0;
         quo_ff[0] <= '0;
         dm_ff[0]  <= dm;
         neg_ff[0] <= nneg ^ dir[W-1];
      end
   end

   // One quotient bit per stage
   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [RW-1:0] r_sh;
      logic          ge;
      always_comb begin
         r_sh = {rem_ff[k][RW-2:0], div_ff[k][N-1]};
         ge   = r_sh >= {1'b0, dm_ff[k]};
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            div_ff[k+1] <= {div_ff[k][N-2:0], 1'b0};
            rem_ff[k+1] <= ge ? (r_sh - {1'b0, dm_ff[k]}) : r_sh;
            quo_ff[k+1] <= {quo_ff[k][N-2:0], ge};
            dm_ff[k+1]  <= dm_ff[k];
            neg_ff[k+1] <= neg_ff[k];
         end
      end
   end

   // Apply sign and saturate
   always_comb begin
      if (neg_ff[N]) begin
         quot_in = (quo_ff[N] > HALF) ? MINV : (~quo_ff[N][W-1:0] + 1'b1);
      end else begin
         quot_in = (quo_ff[N] > MAXQ) ? MAXV : quo_ff[N][W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;
endmodule

// ===== rtl/rbsi_axis_lane.sv =====
// One axis of the slab test: corner sort, two divides, interval ordering.
`timescale 1ns / 1ps
module rbsi_axis_lane #(
   parameter int W = 32
) (
   input  logic                clock,
   input  logic                adv,
   input  logic signed [W-1:0] corner_a,
   input  logic signed [W-1:0] corner_b,
   input  logic signed [W-1:0] origin,
   input  logic signed [W-1:0] dir,
   output logic signed [W-1:0] t_lo,
   output logic signed [W-1:0] t_hi
);
   localparam int LD = W + 1 + rbsi_pkg::FRAC_BITS + 2;
   localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};

   logic signed [W-1:0] lo_plane;
   logic signed [W-1:0] hi_plane;
   logic signed [W-1:0] qa;
   logic signed [W-1:0] qb;
   logic                zero_ff   [0:LD-1];
   logic                inside_ff [0:LD-1];
   logic signed [W-1:0] t_lo_ff;
   logic signed [W-1:0] t_hi_ff;
   logic signed [W-1:0] t_lo_in;
   logic signed [W-1:0] t_hi_in;

   // Sort corners into the slab planes
   always_comb begin
      lo_plane = (corner_b < corner_a) ? corner_b : corner_a;
      hi_plane = (corner_a < corner_b) ? corner_b : corner_a;
   end

   rbsi_div_lane #(.W(W)) u_div_lo (
      .clock(clock), .adv(adv), .plane(lo_plane), .origin(origin), .dir(dir), .quot(qa)
   );

   rbsi_div_lane #(.W(W)) u_div_hi (
      .clock(clock), .adv(adv), .plane(hi_plane), .origin(origin), .dir(dir), .quot(qb)
   );

   // Carry zero-direction flags alongside the dividers
   always_ff @(posedge clock) begin
      if (adv) begin
         zero_ff[0]   <= dir == '0;
         inside_ff[0] <= !(origin < lo_plane) && !(hi_plane < origin);
         for (int k = 1; k < LD; k++) begin
            zero_ff[k]   <= zero_ff[k-1];
            inside_ff[k] <= inside_ff[k-1];
         end
      end
   end

   // Order the two plane hits, or take the whole or empty range
   always_comb begin
      if (zero_ff[LD-1]) begin
         t_lo_in = inside_ff[LD-1] ? MINV : MAXV;
         t_hi_in = inside_ff[LD-1] ? MAXV : MINV;
      end else begin
         t_lo_in = (qb < qa) ? qb : qa;
         t_hi_in = (qa < qb) ? qb : qa;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t_lo_ff <= t_lo_in;
         t_hi_ff <= t_hi_in;
      end
   end

   assign t_lo = t_lo_ff;
   assign t_hi = t_hi_ff;
endmodule

// ===== rtl/rbsi_merge.sv =====
// Merge of the three axis intervals into the result register.
`timescale 1ns / 1ps
module rbsi_merge #(
   parameter int W = 32
) (
   input  logic                clock,
   input  logic                load,
   input  logic signed [W-1:0] lo_x,
   input  logic signed [W-1:0] lo_y,
   input  logic signed [W-1:0] lo_z,
   input  logic signed [W-1:0] hi_x,
   input  logic signed [W-1:0] hi_y,
   input  logic signed [W-1:0] hi_z,
   output logic signed [W-1:0] t_near,
   output logic signed [W-1:0] t_far
);
   logic signed [W-1:0] near_xy;
   logic signed [W-1:0] far_xy;
   logic signed [W-1:0] t_near_in;
   logic signed [W-1:0] t_far_in;
   logic signed [W-1:0] t_near_ff;
   logic signed [W-1:0] t_far_ff;

   // Largest entry, smallest exit
   always_comb begin
      near_xy   = (lo_x < lo_y) ? lo_y : lo_x;
      t_near_in = (near_xy < lo_z) ? lo_z : near_xy;
      far_xy    = (hi_y < hi_x) ? hi_y : hi_x;
      t_far_in  = (hi_z < far_xy) ? hi_z : far_xy;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         t_near_ff <= t_near_in;
         t_far_ff  <= t_far_in;
      end
   end

   assign t_near = t_near_ff;
   assign t_far  = t_far_ff;
endmodule
